@@ rtl/core/i2a_pkg.sv @@
// Shared types, constants and the digit encoding function of the integer to ASCII formatter.
package i2a_pkg;

    typedef enum logic [1:0] {
        OP_DEC  = 2'd0,
        OP_HEXL = 2'd1,
        OP_HEXU = 2'd2,
        OP_PTR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PFX0,
        ST_PFX1,
        ST_DIGIT
    } t_state;

    localparam int BIN_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int NIBBLES    = 16;
    localparam int DIG_W      = 4 * NIBBLES;
    localparam int CNT_W      = $clog2(NIBBLES + 1);
    localparam int DCNT_W     = $clog2(BIN_W + 1);

    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] OFS_LOWER = 8'd87;
    localparam logic [7:0] OFS_UPPER = 8'd55;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ofs;
        ofs = upper ? OFS_UPPER : OFS_LOWER;
        if (d > 4'd9) begin
            return {4'b0, d} + ofs;
        end
        return {4'b0, d} + CH_ZERO;
    endfunction

endpackage

@@ rtl/core/integer_to_ascii_formatter.sv @@
// Top level: nibble shift register, leading zero skip and character sequencer.
// Sequence: hex and pointer values are loaded, then the leading zero skip drops one nibble per
// cycle, then characters follow one per cycle; decimal values first pass through the serial
// BCD converter. One transaction at a time: a new one is accepted only in the idle state.
// Characters come out one per cycle with o_strobe and cannot be stalled. Synchronous
// active-low reset returns the sequencer to idle at once.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_value,
    input  logic        i_alt_form,
    output logic        o_strobe,
    output logic [7:0]  o_char_out,
    output logic        o_last_char
);
    import i2a_pkg::*;

    t_state           r_state, n_state;
    t_op              r_op, n_op, in_op;
    logic             r_alt, n_alt;
    logic             r_nonzero, n_nonzero;
    logic [DIG_W-1:0] r_digits, n_digits;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;
    logic             accept;
    logic             dab_load;
    logic             dab_done;
    logic [BCD_W-1:0] dab_bcd;
    logic             skip_more;
    logic             need_pfx;
    logic [3:0]       top_nib;

    assign in_op    = t_op'(i_operation);
    assign accept   = start && (r_state == ST_IDLE);
    assign dab_load = accept && (in_op == OP_DEC);
    assign top_nib  = r_digits[DIG_W-1 -: 4];

    assign skip_more = (top_nib == 4'd0) && (r_cnt > CNT_W'(1));
    assign need_pfx  = (r_op == OP_PTR) || (r_alt && r_nonzero && r_op != OP_DEC);

    i2a_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dab_load),
        .i_bin   (i_value[BIN_W-1:0]),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (in_op == OP_DEC) ? ST_CONV : ST_SKIP;
                end
            end
            ST_CONV: begin
                if (dab_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!skip_more) begin
                    n_state = need_pfx ? ST_PFX0 : ST_DIGIT;
                end
            end
            ST_PFX0:  n_state = ST_PFX1;
            ST_PFX1:  n_state = ST_DIGIT;
            ST_DIGIT: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_alt     = r_alt;
        n_nonzero = r_nonzero;
        n_digits  = r_digits;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op  = in_op;
                    n_alt = i_alt_form;
                    if (in_op == OP_PTR) begin
                        n_nonzero = |i_value;
                        n_digits  = i_value;
                        n_cnt     = CNT_W'(NIBBLES);
                    end else begin
                        n_nonzero = |i_value[BIN_W-1:0];
                        n_digits  = {i_value[BIN_W-1:0], {(DIG_W-BIN_W){1'b0}}};
                        n_cnt     = CNT_W'(BIN_W / 4);
                    end
                end
            end
            ST_CONV: begin
                if (dab_done) begin
                    n_digits = {dab_bcd, {(DIG_W-BCD_W){1'b0}}};
                    n_cnt    = CNT_W'(BCD_DIGITS);
                end
            end
            ST_SKIP: begin
                if (skip_more) begin
                    n_digits = {r_digits[DIG_W-5:0], 4'd0};
                    n_cnt    = r_cnt - CNT_W'(1);
                end
            end
            ST_PFX0: begin
                n_strobe = 1'b1;
                n_char   = CH_ZERO;
            end
            ST_PFX1: begin
                n_strobe = 1'b1;
                n_char   = (r_op == OP_HEXU) ? CH_UP_X : CH_LOW_X;
            end
            ST_DIGIT: begin
                n_strobe = 1'b1;
                n_char   = digit_char(top_nib, r_op == OP_HEXU);
                n_last   = (r_cnt == CNT_W'(1));
                n_digits = {r_digits[DIG_W-5:0], 4'd0};
                n_cnt    = r_cnt - CNT_W'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_alt     <= n_alt;
        r_nonzero <= n_nonzero;
        r_digits  <= n_digits;
        r_cnt     <= n_cnt;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

endmodule

@@ rtl/core/i2a_dabble.sv @@
// Serial binary to BCD converter using shift-and-add-3, one input bit per cycle.
module i2a_dabble (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic [i2a_pkg::BIN_W-1:0] i_bin,
    output logic                     o_done,
    output logic [i2a_pkg::BCD_W-1:0] o_bcd
);
    import i2a_pkg::*;

    logic [BIN_W-1:0]  r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  n_adj;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_run;
    logic              r_done;

    // Each BCD digit of 5 or more gets 3 added before the shift.
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                n_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                n_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == DCNT_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_bin;
            r_bcd <= '0;
            r_cnt <= DCNT_W'(BIN_W);
        end else if (r_run) begin
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[BIN_W-1]};
            r_bin <= {r_bin[BIN_W-2:0], 1'b0};
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ rtl/core/i2a_checker.sv @@
// Port-level checker for the integer to ASCII formatter and its bind statement.
module i2a_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_last_char,
    input logic [7:0] o_char_out
);

    // A transaction that is taken makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Characters of one conversion come out in consecutive cycles.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_char |=> o_strobe)
        else $error("gap inside a conversion");

    // A character seen while idle must be the final one of its conversion.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_last_char)
        else $error("non-final character after busy dropped");

    // No character appears unless the block was working in the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("character without a transaction in progress");

    // Every strobed character carries known bits.
    a_known_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$isunknown({o_char_out, o_last_char}))
        else $error("strobed character has unknown bits");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_last_char (o_last_char),
    .o_char_out  (o_char_out)
);

@@ bench/testbench.sv @@
// Self-checking testbench for integer_to_ascii_formatter: directed and random conversions.
module testbench;
    import i2a_pkg::*;

    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] LOWER_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_OFFSET = 8'd55;
    localparam logic [7:0] CHAR_X_LOWER = 8'h78;
    localparam logic [7:0] CHAR_X_UPPER = 8'h58;
    localparam int         DRAIN_LIMIT  = 5000;
    localparam int         SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [63:0] i_value;
    logic        i_alt_form;
    logic        o_strobe;
    logic [7:0]  o_char_out;
    logic        o_last_char;

    text_char_t expected_chars[$];
    int         mismatch_count = 0;
    bit         idle_enabled = 1'b0;

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_alt_form  (i_alt_form),
        .o_strobe    (o_strobe),
        .o_char_out  (o_char_out),
        .o_last_char (o_last_char)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Appends the text that one conversion must produce to the expected characters.
    function automatic void format_expected(input t_op op, input logic [63:0] value,
                                            input logic alt);
        logic [63:0] mag;
        logic [7:0]  text[0:19];
        logic [7:0]  digits[0:19];
        logic [3:0]  nibble;
        int          n;
        int          nd;
        text_char_t  item;
        n = 0;
        nd = 0;
        mag = (op == OP_PTR) ? value : {32'b0, value[31:0]};
        if (mag == 64'd0) begin
            if (op == OP_PTR) begin
                text[n++] = ASCII_ZERO;
                text[n++] = CHAR_X_LOWER;
            end
            text[n++] = ASCII_ZERO;
        end else if (op == OP_DEC) begin
            while (mag != 64'd0) begin
                digits[nd++] = 8'(mag % 64'd10) + ASCII_ZERO;
                mag = mag / 64'd10;
            end
        end else begin
            if (op == OP_PTR || alt) begin
                text[n++] = ASCII_ZERO;
                text[n++] = (op == OP_HEXU) ? CHAR_X_UPPER : CHAR_X_LOWER;
            end
            while (mag != 64'd0) begin
                nibble = mag[3:0];
                if (nibble > 4'd9) begin
                    digits[nd++] = {4'b0, nibble} +
                                   ((op == OP_HEXU) ? UPPER_OFFSET : LOWER_OFFSET);
                end else begin
                    digits[nd++] = {4'b0, nibble} + ASCII_ZERO;
                end
                mag = mag >> 4;
            end
        end
        for (int i = nd - 1; i >= 0; i--) begin
            text[n++] = digits[i];
        end
        for (int i = 0; i < n; i++) begin
            item.ch = text[i];
            item.last = (i == n - 1);
            expected_chars.push_back(item);
        end
    endfunction

    // Start stays high after acceptance; the next call or the drain changes it.
    task automatic send_conversion(input t_op op, input logic [63:0] value, input logic alt);
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        while (idle_enabled && $urandom_range(99) < 35) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_operation = op;
        i_value = value;
        i_alt_form = alt;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        format_expected(op, value, alt);
    endtask

    task automatic send_random_conversion();
        logic [63:0] value;
        logic [31:0] power;
        value = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            // Random magnitude so that the leading zero skip sees every length.
            1: value = value >> $urandom_range(63);
            2: value = {$urandom, 32'd0} | 64'($urandom_range(20)) | ($urandom_range(3) == 0 ?
                       64'd0 : 64'd0);
            default: begin
                power = 32'd1;
                repeat ($urandom_range(9)) power = power * 32'd10;
                value = {$urandom, power - 32'd1 + 32'($urandom_range(2))};
            end
        endcase
        if ($urandom_range(15) == 0) begin
            value = (value & {$urandom, $urandom}) & ($urandom_range(1) ? 64'hFFFF_FFFF_0000_0000
                                                                        : 64'd0);
        end
        send_conversion(t_op'($urandom_range(3)), value, 1'($urandom_range(1)));
    endtask

    task automatic test_zero_values();
        for (int op = 0; op < 4; op++) begin
            send_conversion(t_op'(op), 64'd0, 1'b0);
            send_conversion(t_op'(op), 64'd0, 1'b1);
        end
    endtask

    task automatic test_extreme_values();
        for (int op = 0; op < 4; op++) begin
            send_conversion(t_op'(op), 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
            send_conversion(t_op'(op), 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        end
        send_conversion(OP_DEC, 64'd1, 1'b1);
        send_conversion(OP_HEXU, 64'h0000_0000_ABCD_EF09, 1'b1);
        send_conversion(OP_PTR, 64'h8000_0000_0000_0000, 1'b1);
        send_conversion(OP_PTR, 64'd1, 1'b0);
    endtask

    // Kinds other than pointer look only at the low word.
    task automatic test_upper_bits_ignored();
        send_conversion(OP_DEC, 64'hFFFF_FFFF_0000_0000, 1'b0);
        send_conversion(OP_HEXL, 64'hFFFF_FFFF_0000_0000, 1'b1);
        send_conversion(OP_HEXU, 64'h1234_5678_0000_00A0, 1'b1);
        send_conversion(OP_DEC, 64'hDEAD_BEEF_3B9A_CA00, 1'b0);
    endtask

    task automatic test_random_with_idling();
        idle_enabled = 1'b1;
        repeat (200) send_random_conversion();
    endtask

    task automatic test_random_back_to_back();
        idle_enabled = 1'b0;
        repeat (140) send_random_conversion();
    endtask

    always @(posedge i_clk) begin
        text_char_t want;
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time, o_char_out,
                         o_last_char);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_char_out !== want.ch) begin
                    $display("%0t: char_out expected %h actual %h", $time, want.ch, o_char_out);
                    mismatch_count++;
                end
                if (o_last_char !== want.last) begin
                    $display("%0t: last_char expected %b actual %b", $time, want.last,
                             o_last_char);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = 2'd0;
        i_value = 64'd0;
        i_alt_form = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_values();
        test_extreme_values();
        test_upper_bits_ignored();
        test_random_with_idling();
        test_random_back_to_back();

        @(negedge i_clk);
        start = 1'b0;
        waited = 0;
        while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d expected characters never arrived", $time,
                     expected_chars.size());
        end
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("integer_to_ascii_formatter verification clean");
        end else begin
            $display("integer_to_ascii_formatter verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("integer_to_ascii_formatter verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/i2a_pkg.sv
rtl/core/i2a_dabble.sv
rtl/core/integer_to_ascii_formatter.sv
rtl/core/i2a_checker.sv
bench/testbench.sv
